@@ src/arh_pkg.sv @@
// arh_pkg: shared types and codes for the activity residency history unit
// no dependencies
package arh_pkg;

	localparam int unsigned FIELD_BITS = 48;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ORDER     = 3'd1,
		ST_BAD_WIN   = 3'd2,
		ST_UNSEEN    = 3'd3,
		ST_EXPOSURE  = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		ACT_IDLE     = 2'd0,
		ACT_NORMAL   = 2'd1,
		ACT_RECOVERY = 2'd2,
		ACT_OTHER    = 2'd3
	} act_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_OBS_RD,
		BK_OBS_WAIT,
		BK_OBS_EXEC,
		BK_Q_SETUP,
		BK_Q_RD,
		BK_Q_WAIT,
		BK_Q_STEP,
		BK_Q_TOT,
		BK_Q_SUB,
		BK_Q_CMP,
		BK_DONE
	} bk_state_t;

endpackage

@@ src/arh_front.sv @@
// arh_front: accepts items, masks and classifies them, and queues them for the back end
// depends on arh_pkg
module arh_front #(
	parameter int unsigned NODE_BITS = 4,
	parameter int unsigned NODE_COUNT = 16,
	parameter int unsigned TIME_BITS = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic mode,
	input  logic [3:0] node,
	input  logic [47:0] event_time,
	input  logic [1:0] activity,
	input  logic [47:0] window_begin,
	input  logic [47:0] window_end,
	input  logic [47:0] as_of,
	input  logic [47:0] exposure_limit,
	output logic q_valid,
	input  logic q_ready,
	output logic q_mode,
	output logic q_node_ok,
	output logic q_bad_win,
	output logic [NODE_BITS-1:0] q_node,
	output logic [TIME_BITS-1:0] q_t,
	output logic [1:0] q_act,
	output logic [TIME_BITS-1:0] q_wb,
	output logic [TIME_BITS-1:0] q_we,
	output logic [TIME_BITS-1:0] q_expo
);
	import arh_pkg::*;

	localparam int unsigned W = (TIME_BITS < FIELD_BITS) ? TIME_BITS : FIELD_BITS;
	localparam int unsigned QW = 3 + NODE_BITS + 2 + 4 * TIME_BITS;

	logic [QW-1:0] fifo_q [2];
	logic [1:0] cnt_q;
	logic wr_ptr_q, rd_ptr_q;
	logic [TIME_BITS-1:0] t_m, wb_m, we_m, ao_m, ex_m;
	logic node_ok, bad_win;
	logic [1:0] act_m;
	logic [NODE_BITS-1:0] node_m;
	logic push, pop;

	always_comb begin
		t_m = '0; wb_m = '0; we_m = '0; ao_m = '0; ex_m = '0;
		t_m[W-1:0] = event_time[W-1:0];
		wb_m[W-1:0] = window_begin[W-1:0];
		we_m[W-1:0] = window_end[W-1:0];
		ao_m[W-1:0] = as_of[W-1:0];
		ex_m[W-1:0] = exposure_limit[W-1:0];
		node_ok = ({28'd0, node} < 32'(NODE_COUNT));
		node_m = NODE_BITS'(node);
		act_m = (activity == ACT_OTHER) ? ACT_IDLE : activity;
		bad_win = (we_m < wb_m) || (ao_m < we_m) || (ex_m > ao_m);
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign {q_mode, q_node_ok, q_bad_win, q_node, q_act, q_t, q_wb, q_we, q_expo} =
		fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= {mode, node_ok, bad_win, node_m, act_m, t_m, wb_m, we_m, ex_m};
	end

endmodule

@@ src/arh_back.sv @@
// arh_back: history memory, observe update and windowed binary search
// depends on arh_pkg
module arh_back #(
	parameter int unsigned NODE_BITS = 4,
	parameter int unsigned NODE_COUNT = 16,
	parameter int unsigned HISTORY_DEPTH = 64,
	parameter int unsigned TIME_BITS = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  logic q_mode,
	input  logic q_node_ok,
	input  logic q_bad_win,
	input  logic [NODE_BITS-1:0] q_node,
	input  logic [TIME_BITS-1:0] q_t,
	input  logic [1:0] q_act,
	input  logic [TIME_BITS-1:0] q_wb,
	input  logic [TIME_BITS-1:0] q_we,
	input  logic [TIME_BITS-1:0] q_expo,
	output logic out_valid,
	input  logic out_ready,
	output logic [47:0] normal_time,
	output logic [47:0] recovery_time,
	output logic [47:0] exposed_time,
	output logic [2:0] status
);
	import arh_pkg::*;

	localparam int unsigned IB = (HISTORY_DEPTH > 2) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int unsigned CB = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned AB = NODE_BITS + IB;
	localparam int unsigned ENT = 1 << AB;
	localparam int unsigned EW = 3 * TIME_BITS + 2;
	localparam int unsigned W = (TIME_BITS < FIELD_BITS) ? TIME_BITS : FIELD_BITS;

	logic [EW-1:0] mem [ENT];
	logic [EW-1:0] rd_q;
	logic [AB-1:0] raddr, waddr;
	logic wen, ren;
	logic [EW-1:0] wdata;

	logic [TIME_BITS-1:0] last_seen_q [NODE_COUNT];
	logic [NODE_COUNT-1:0] seen_q;
	logic [CB-1:0] count_q [NODE_COUNT];

	bk_state_t state_q, state_d;
	logic [CB-1:0] lo_q, hi_q, lo_d, hi_d;
	logic pass_q, pass_d;
	logic [TIME_BITS-1:0] n0_q, r0_q, n0_d, r0_d, nrm_q, rec_q, nrm_d, rec_d;
	logic [TIME_BITS-1:0] exp_q, exp_d;
	logic [2:0] st_q, st_d;
	logic [TIME_BITS-1:0] out_nrm_q, out_rec_q, out_exp_q;
	logic [2:0] out_st_q;
	logic out_ld;
	logic [TIME_BITS-1:0] tgt;
	logic [CB-1:0] mid, cnt, sel;
	logic [TIME_BITS-1:0] e_stamp, e_nrm, e_rec, d, tn, tr;
	logic [1:0] e_act;
	logic seen, out_v_q, out_v_d;
	logic upd_node, upd_cnt;
	logic [TIME_BITS-1:0] live;
	logic [TIME_BITS:0] sum;

	assign cnt = count_q[q_node];
	assign seen = seen_q[q_node] && (cnt != '0);
	assign {e_stamp, e_nrm, e_rec, e_act} = rd_q;
	assign tgt = pass_q ? q_we : q_wb;
	assign mid = CB'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign sel = (lo_q == '0) ? '0 : lo_q - 1'b1;

	always_comb begin
		logic [TIME_BITS-1:0] tt;
		tt = (state_q == BK_OBS_EXEC) ? q_t : tgt;
		d = (tt >= e_stamp) ? tt - e_stamp : '0;
		tn = e_nrm + ((e_act == ACT_NORMAL) ? d : '0);
		tr = e_rec + ((e_act == ACT_RECOVERY) ? d : '0);
	end

	always_comb begin
		state_d = state_q;
		lo_d = lo_q; hi_d = hi_q; pass_d = pass_q;
		n0_d = n0_q; r0_d = r0_q; nrm_d = nrm_q; rec_d = rec_q; exp_d = exp_q;
		st_d = st_q;
		out_v_d = out_v_q;
		out_ld = 1'b0;
		q_ready = 1'b0;
		raddr = {q_node, IB'(0)};
		waddr = {q_node, IB'(0)};
		wen = 1'b0;
		ren = 1'b0;
		wdata = '0;
		upd_node = 1'b0;
		upd_cnt = 1'b0;
		live = (q_we < q_expo) ? q_we : q_expo;
		sum = {1'b0, nrm_q} + {1'b0, rec_q};
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					nrm_d = '0; rec_d = '0; exp_d = '0; st_d = ST_OK;
					if (!q_node_ok && (!q_mode || !q_bad_win)) begin
						st_d = ST_UNSEEN; state_d = BK_DONE;
					end else if (q_mode) begin
						if (q_bad_win) begin
							st_d = ST_BAD_WIN; state_d = BK_DONE;
						end else if (!seen) begin
							st_d = ST_UNSEEN; state_d = BK_DONE;
						end else begin
							pass_d = 1'b0; state_d = BK_Q_SETUP;
						end
					end else if (!seen) begin
						// seed entry at time 0: idle, or the item's own activity when the item is at time 0
						wen = 1'b1;
						if (q_t == '0) begin
							wdata = {{(3*TIME_BITS){1'b0}}, q_act};
						end else begin
							wdata = '0;
						end
						upd_node = 1'b1;
						state_d = BK_DONE;
						if (q_t != '0 && q_act != ACT_IDLE)
							state_d = BK_OBS_RD;
					end else if (q_t < last_seen_q[q_node]) begin
						st_d = ST_ORDER; state_d = BK_DONE;
					end else begin
						state_d = BK_OBS_RD;
					end
				end
			end
			BK_OBS_RD: begin
				raddr = {q_node, IB'(cnt - 1'b1)};
				ren = 1'b1;
				state_d = BK_OBS_WAIT;
			end
			BK_OBS_WAIT: state_d = BK_OBS_EXEC;
			BK_OBS_EXEC: begin
				state_d = BK_DONE;
				if (q_t == e_stamp) begin
					wen = 1'b1;
					waddr = {q_node, IB'(cnt - 1'b1)};
					wdata = {e_stamp, tn, tr, q_act};
					upd_node = 1'b1;
				end else if (q_act != e_act) begin
					if ({1'b0, cnt} >= (CB + 1)'(HISTORY_DEPTH)) begin
						st_d = ST_FULL;
					end else begin
						wen = 1'b1;
						waddr = {q_node, IB'(cnt)};
						wdata = {q_t, tn, tr, q_act};
						upd_node = 1'b1;
						upd_cnt = 1'b1;
					end
				end else begin
					upd_node = 1'b1;
				end
			end
			BK_Q_SETUP: begin
				lo_d = '0; hi_d = cnt; state_d = BK_Q_RD;
			end
			BK_Q_RD: begin
				ren = 1'b1;
				if (lo_q < hi_q) begin
					raddr = {q_node, IB'(mid)};
					state_d = BK_Q_WAIT;
				end else begin
					raddr = {q_node, IB'(sel)};
					state_d = BK_Q_TOT;
				end
			end
			BK_Q_WAIT: state_d = BK_Q_STEP;
			BK_Q_STEP: begin
				if (e_stamp <= tgt) lo_d = mid + 1'b1;
				else hi_d = mid;
				state_d = BK_Q_RD;
			end
			BK_Q_TOT: begin
				state_d = pass_q ? BK_Q_SUB : BK_Q_SETUP;
				if (pass_q) begin
					nrm_d = tn; rec_d = tr;
				end else begin
					n0_d = tn; r0_d = tr; pass_d = 1'b1;
				end
			end
			BK_Q_SUB: begin
				nrm_d = nrm_q - n0_q;
				rec_d = rec_q - r0_q;
				exp_d = (live > q_wb) ? live - q_wb : '0;
				state_d = BK_Q_CMP;
			end
			BK_Q_CMP: begin
				if (sum > {1'b0, exp_q}) st_d = ST_EXPOSURE;
				state_d = BK_DONE;
			end
			BK_DONE: begin
				if (!out_v_q || out_ready) begin
					out_v_d = 1'b1;
					out_ld = 1'b1;
					q_ready = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
		if (out_v_q && out_ready && !(state_q == BK_DONE)) out_v_d = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_v_q <= 1'b0;
			seen_q <= '0;
			for (int i = 0; i < NODE_COUNT; i++) begin
				count_q[i] <= '0;
				last_seen_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			out_v_q <= out_v_d;
			if (upd_node) begin
				seen_q[q_node] <= 1'b1;
				last_seen_q[q_node] <= q_t;
				if (!seen) count_q[q_node] <= CB'(1);
				if (upd_cnt) count_q[q_node] <= cnt + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q <= lo_d; hi_q <= hi_d; pass_q <= pass_d;
		n0_q <= n0_d; r0_q <= r0_d; nrm_q <= nrm_d; rec_q <= rec_d;
		exp_q <= exp_d; st_q <= st_d;
		if (out_ld) begin
			out_nrm_q <= nrm_q;
			out_rec_q <= rec_q;
			out_exp_q <= exp_q;
			out_st_q <= st_q;
		end
		if (wen) mem[waddr] <= wdata;
		if (ren) rd_q <= mem[raddr];
	end

	always_comb begin
		normal_time = '0; recovery_time = '0; exposed_time = '0;
		normal_time[W-1:0] = out_nrm_q[W-1:0];
		recovery_time[W-1:0] = out_rec_q[W-1:0];
		exposed_time[W-1:0] = out_exp_q[W-1:0];
	end
	assign out_valid = out_v_q;
	assign status = out_st_q;

endmodule

@@ src/activity_residency_history_unit.sv @@
// activity_residency_history_unit: top level, front queue plus history back end
// depends on arh_pkg, arh_front, arh_back
// search steps per window point: up to log2(history depth) + 1
// the back end handles one item at a time; the front queue holds up to two items, including the one in progress
// reset: arst_n clears node state and control; history memory needs no clearing
module activity_residency_history_unit #(
	parameter int unsigned NODE_COUNT = 16,
	parameter int unsigned HISTORY_DEPTH = 64,
	parameter int unsigned TIME_BITS = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic mode,
	input  logic [3:0] node,
	input  logic [47:0] event_time,
	input  logic [1:0] activity,
	input  logic [47:0] window_begin,
	input  logic [47:0] window_end,
	input  logic [47:0] as_of,
	input  logic [47:0] exposure_limit,
	output logic out_valid,
	input  logic out_ready,
	output logic [47:0] normal_time,
	output logic [47:0] recovery_time,
	output logic [47:0] exposed_time,
	output logic [2:0] status
);
	import arh_pkg::*;

	localparam int unsigned NODE_BITS = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

	logic q_valid, q_ready, q_mode, q_node_ok, q_bad_win;
	logic [NODE_BITS-1:0] q_node;
	logic [TIME_BITS-1:0] q_t, q_wb, q_we, q_expo;
	logic [1:0] q_act;

	arh_front #(.NODE_BITS(NODE_BITS), .NODE_COUNT(NODE_COUNT), .TIME_BITS(TIME_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .mode, .node, .event_time, .activity,
		.window_begin, .window_end, .as_of, .exposure_limit,
		.q_valid, .q_ready, .q_mode, .q_node_ok, .q_bad_win, .q_node, .q_t, .q_act,
		.q_wb, .q_we, .q_expo
	);

	arh_back #(.NODE_BITS(NODE_BITS), .NODE_COUNT(NODE_COUNT),
		.HISTORY_DEPTH(HISTORY_DEPTH), .TIME_BITS(TIME_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_mode, .q_node_ok, .q_bad_win, .q_node,
		.q_t, .q_act, .q_wb, .q_we, .q_expo,
		.out_valid, .out_ready, .normal_time, .recovery_time, .exposed_time, .status
	);

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_FULL)) else $error("status code out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)) else $error("result dropped");
	a_observe_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_ORDER || status == ST_FULL) |->
		normal_time == '0 && exposed_time == '0) else $error("observe result not zero");

endmodule
